// ===== rtl/gsa_pkg.sv =====
// Shared types and constants for the generational slot allocator.
// Used by the top level, the checker module and the testbench; depends on nothing.
package gsa_pkg;

  localparam int SLOTS_DEF    = 1024;
  localparam int GEN_BITS_DEF = 16;

  localparam int OP_W   = 3;
  localparam int SLOT_W = 10;
  localparam int GEN_W  = 16;

  // alive bits are stored one row of ROW_W slots per memory word
  localparam int ROW_W  = 32;
  localparam int ROW_BW = 5;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [GEN_W-1:0]  gen_t;

  typedef enum logic [OP_W-1:0] {
    OP_CREATE   = 3'd0,
    OP_ACTIVATE = 3'd1,
    OP_KILL     = 3'd2,
    OP_GET      = 3'd3,
    OP_CHECK    = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_GEN,
    ST_ACC
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0] operation;
    slot_t           slot_in;
    gen_t            generation_in;
    logic            start_alive;
  } req_t;

  typedef struct packed {
    slot_t slot_out;
    gen_t  generation_out;
    logic  ok;
    logic  full_res;
  } rsp_t;

endpackage

// ===== rtl/gsa_stream_if.sv =====
// Valid/ready channel carrying one word of payload type T.
// Payload types come from gsa_pkg.
interface gsa_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/gsa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/gsa_ffz.sv =====
// Find the lowest clear bit of a vector (priority encoder).
// No dependencies.
module gsa_ffz #(
  parameter int N = 32,
  localparam int IW = (N > 1) ? $clog2(N) : 1
) (
  input  logic [N-1:0]  vec_i,
  output logic          found_o,
  output logic [IW-1:0] idx_o
);

  always_comb begin
    found_o = 1'b0;
    idx_o   = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!vec_i[i]) begin
        found_o = 1'b1;
        idx_o   = IW'(i);
      end
    end
  end

endmodule

// ===== rtl/generational_slot_allocator_top.sv =====
// Generational slot allocator: alive-bit row memory, generation memory, control.
// Depends on gsa_pkg, gsa_stream_if, gsa_ram and gsa_ffz.
//
// channel | dir | payload     | accepted when
// req_i   | in  | gsa_pkg::req_t | req_i.valid && req_i.ready
// rsp_o   | out | gsa_pkg::rsp_t | rsp_o.valid && rsp_o.ready
//
// Create shows its result after a row read, then a generation read and write, or after
// the row read alone when no slot is free; all other operations show it after a row and
// generation read, with a row write back for activate and kill. One word is in flight;
// the next is accepted once the result is registered and the control is back in idle.
// A held result register lets a new word in while the previous result waits.
// Reset clears the alive-row full flags and the used count; memories need no sweep.
module generational_slot_allocator_top #(
  parameter int SLOTS    = gsa_pkg::SLOTS_DEF,
  parameter int GEN_BITS = gsa_pkg::GEN_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  gsa_stream_if.sink   req_i,
  gsa_stream_if.source rsp_o
);

  localparam int RowW   = gsa_pkg::ROW_W;
  localparam int RowBW  = gsa_pkg::ROW_BW;
  localparam int IdxW   = $clog2(SLOTS);
  localparam int Rows   = (SLOTS + RowW - 1) / RowW;
  localparam int RowAW  = (Rows > 1) ? $clog2(Rows) : 1;
  localparam int PadW   = RowAW + RowBW;
  localparam int CntW   = $clog2(SLOTS + 1);
  localparam int CmpW   = ((PadW > gsa_pkg::SLOT_W) ? PadW : gsa_pkg::SLOT_W) + 1;
  localparam int GCmpW  = (GEN_BITS > gsa_pkg::GEN_W) ? GEN_BITS : gsa_pkg::GEN_W;

  gsa_pkg::state_e   state_q, state_d;
  gsa_pkg::req_t     req_q, req_d;
  logic [RowAW-1:0]  row_q, row_d;
  logic              none_q, none_d;
  logic [RowBW-1:0]  pos_q, pos_d;
  logic              fresh_q, fresh_d;
  logic [RowW-1:0]   newrow_q, newrow_d;
  logic              newfull_q, newfull_d;
  logic [CntW-1:0]   used_q, used_d;
  logic [Rows-1:0]   full_q, full_d;
  gsa_pkg::rsp_t     rsp_q, rsp_d;
  logic              rsp_vld_q, rsp_vld_d;

  logic              row_found;
  logic [RowAW-1:0]  row_free;
  logic [PadW-1:0]   in_pad;
  logic [PadW-1:0]   slot_pad_q;
  logic [RowBW-1:0]  slot_pos;
  logic [RowW-1:0]   alive_rd;
  logic [RowW-1:0]   eff;
  logic              bit_found;
  logic [RowBW-1:0]  bit_pos;
  logic [RowBW-1:0]  sel_pos;
  logic              sel_val;
  logic [RowW-1:0]   new_row;
  logic              slot_used;
  logic              fire;
  logic [GEN_BITS-1:0] gen_rd;
  logic [GEN_BITS-1:0] gen_new;
  logic [PadW-1:0]   look_idx;
  logic [PadW-1:0]   gen_idx;

  logic              al_we, al_re;
  logic [RowAW-1:0]  al_raddr;
  logic [RowW-1:0]   al_wdata;
  logic              gn_we, gn_re;
  logic [IdxW-1:0]   gn_raddr;

  gsa_ffz #(.N(Rows)) u_row_ffz (
    .vec_i   (full_q),
    .found_o (row_found),
    .idx_o   (row_free)
  );

  gsa_ffz #(.N(RowW)) u_bit_ffz (
    .vec_i   (eff),
    .found_o (bit_found),
    .idx_o   (bit_pos)
  );

  gsa_ram #(.WIDTH(RowW), .DEPTH(Rows)) u_alive_ram (
    .clk_i   (clk_i),
    .we_i    (al_we),
    .waddr_i (row_q),
    .wdata_i (al_wdata),
    .re_i    (al_re),
    .raddr_i (al_raddr),
    .rdata_o (alive_rd)
  );

  gsa_ram #(.WIDTH(GEN_BITS), .DEPTH(SLOTS)) u_gen_ram (
    .clk_i   (clk_i),
    .we_i    (gn_we),
    .waddr_i (IdxW'(gen_idx)),
    .wdata_i (gen_new),
    .re_i    (gn_re),
    .raddr_i (gn_raddr),
    .rdata_o (gen_rd)
  );

  assign in_pad     = PadW'(req_i.payload.slot_in);
  assign slot_pad_q = PadW'(req_q.slot_in);
  assign slot_pos   = slot_pad_q[RowBW-1:0];
  assign look_idx   = {row_q, bit_pos};
  assign gen_idx    = {row_q, pos_q};
  assign slot_used  = CmpW'(req_q.slot_in) < CmpW'(used_q);
  assign fire       = !rsp_vld_q || rsp_o.ready;

  // alive bits as seen: unused slots read as clear, slots past the end as set
  always_comb begin : p_eff
    logic [CmpW-1:0] base;
    base = CmpW'({row_q, {RowBW{1'b0}}});
    for (int k = 0; k < RowW; k++) begin
      if (base + CmpW'(k) < CmpW'(used_q)) begin
        eff[k] = alive_rd[k];
      end else begin
        eff[k] = (base + CmpW'(k) >= CmpW'(SLOTS));
      end
    end
  end

  assign sel_pos = (state_q == gsa_pkg::ST_LOOK) ? bit_pos : slot_pos;
  assign sel_val = (state_q == gsa_pkg::ST_LOOK) ? req_q.start_alive
                                                 : (req_q.operation == gsa_pkg::OP_ACTIVATE);

  always_comb begin
    new_row          = eff;
    new_row[sel_pos] = sel_val;
  end

  always_comb begin
    if (fresh_q || gen_rd == '1) begin
      gen_new = GEN_BITS'(1);
    end else begin
      gen_new = gen_rd + GEN_BITS'(1);
    end
  end

  assign req_i.ready   = (state_q == gsa_pkg::ST_IDLE);
  assign rsp_o.valid   = rsp_vld_q;
  assign rsp_o.payload = rsp_q;

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    row_d     = row_q;
    none_d    = none_q;
    pos_d     = pos_q;
    fresh_d   = fresh_q;
    newrow_d  = newrow_q;
    newfull_d = newfull_q;
    used_d    = used_q;
    full_d    = full_q;
    rsp_d     = rsp_q;
    rsp_vld_d = rsp_vld_q && !rsp_o.ready;
    al_we     = 1'b0;
    al_re     = 1'b0;
    al_raddr  = row_free;
    al_wdata  = new_row;
    gn_we     = 1'b0;
    gn_re     = 1'b0;
    gn_raddr  = IdxW'(in_pad);

    case (state_q)
      gsa_pkg::ST_IDLE: begin
        if (req_i.valid) begin
          req_d = req_i.payload;
          al_re = 1'b1;
          gn_re = 1'b1;
          if (req_i.payload.operation == gsa_pkg::OP_CREATE) begin
            row_d   = row_free;
            none_d  = !row_found;
            state_d = gsa_pkg::ST_LOOK;
          end else begin
            al_raddr = in_pad[PadW-1:RowBW];
            row_d    = in_pad[PadW-1:RowBW];
            state_d  = gsa_pkg::ST_ACC;
          end
        end
      end
      gsa_pkg::ST_LOOK: begin
        if (none_q) begin
          if (fire) begin
            rsp_d          = '0;
            rsp_d.full_res = 1'b1;
            rsp_vld_d      = 1'b1;
            state_d        = gsa_pkg::ST_IDLE;
          end
        end else begin
          pos_d     = bit_pos;
          fresh_d   = !bit_found || !(CmpW'(look_idx) < CmpW'(used_q));
          newrow_d  = new_row;
          newfull_d = &new_row;
          gn_re     = 1'b1;
          gn_raddr  = IdxW'(look_idx);
          state_d   = gsa_pkg::ST_GEN;
        end
      end
      gsa_pkg::ST_GEN: begin
        if (fire) begin
          al_we                = 1'b1;
          al_wdata             = newrow_q;
          gn_we                = 1'b1;
          full_d[row_q]        = newfull_q;
          used_d               = fresh_q ? used_q + CntW'(1) : used_q;
          rsp_d.slot_out       = gsa_pkg::slot_t'(gen_idx);
          rsp_d.generation_out = gsa_pkg::gen_t'(gen_new);
          rsp_d.ok             = 1'b1;
          rsp_d.full_res       = 1'b0;
          rsp_vld_d            = 1'b1;
          state_d              = gsa_pkg::ST_IDLE;
        end
      end
      gsa_pkg::ST_ACC: begin
        if (fire) begin
          rsp_d                = '0;
          rsp_d.slot_out       = req_q.slot_in;
          rsp_d.generation_out = slot_used ? gsa_pkg::gen_t'(gen_rd) : '0;
          case (req_q.operation)
            gsa_pkg::OP_ACTIVATE: begin
              al_we = slot_used;
            end
            gsa_pkg::OP_KILL: begin
              al_we    = slot_used;
              rsp_d.ok = slot_used && eff[slot_pos];
            end
            gsa_pkg::OP_GET: begin
            end
            gsa_pkg::OP_CHECK: begin
              rsp_d.ok = (req_q.generation_in != '0) && slot_used && eff[slot_pos] &&
                         (GCmpW'(gen_rd) == GCmpW'(req_q.generation_in));
            end
            default: begin
              rsp_d = '0;
            end
          endcase
          if (al_we) begin
            full_d[row_q] = &new_row;
          end
          rsp_vld_d = 1'b1;
          state_d   = gsa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = gsa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= gsa_pkg::ST_IDLE;
      used_q    <= '0;
      full_q    <= '0;
      rsp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      full_q    <= full_d;
      rsp_vld_q <= rsp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    row_q     <= row_d;
    none_q    <= none_d;
    pos_q     <= pos_d;
    fresh_q   <= fresh_d;
    newrow_q  <= newrow_d;
    newfull_q <= newfull_d;
    rsp_q     <= rsp_d;
  end

endmodule

// ===== rtl/gsa_chk.sv =====
// Port-level checks for the generational slot allocator, bound to its top level.
// Depends on gsa_pkg and generational_slot_allocator_top.
module gsa_chk (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_i,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input gsa_pkg::rsp_t out_word_i
);

  // a failed create carries nothing else
  a_full_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_word_i.full_res |->
      !out_word_i.ok && out_word_i.generation_out == '0 && out_word_i.slot_out == '0)
    else $error("full result carries data");

  // one word in flight: input closes right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input open after accept");

  // a new result only appears while a word is being worked
  a_rsp_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result without work in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_word_i))
    else $error("stalled result changed");

endmodule

bind generational_slot_allocator_top gsa_chk u_gsa_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .out_word_i  (rsp_o.payload)
);

// ===== tb/gsa_handle_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the generational slot allocator: predicts every reply word
// from the accepted request words and compares it with the accepted replies.
// Depends on gsa_pkg.
module gsa_handle_checker #(
  parameter int N_SLOTS = gsa_pkg::SLOTS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  input  logic           req_ready_i,
  input  gsa_pkg::req_t  req_word_i,
  input  logic           rsp_valid_i,
  input  logic           rsp_ready_i,
  input  gsa_pkg::rsp_t  rsp_word_i,
  output int             fail_count_o,
  output int             waiting_o,
  output int             checked_o,
  output int             full_seen_o,
  output int             slots_in_use_o
);
  import gsa_pkg::*;

  localparam gen_t GEN_TOP = '1;

  bit   live [N_SLOTS];
  gen_t gen_mem [N_SLOTS];
  int   high_water;
  rsp_t reply_q [$];
  rsp_t want;

  function automatic rsp_t next_reply(req_t w);
    rsp_t r;
    int   pick;
    logic seen;
    r = '0;
    pick = -1;
    if (w.operation == OP_CREATE) begin
      for (int i = 0; i < high_water; i++) begin
        if (pick < 0 && !live[i]) pick = i;
      end
      if (pick >= 0) begin
        gen_mem[pick] = (gen_mem[pick] == GEN_TOP) ? gen_t'(1) : gen_mem[pick] + gen_t'(1);
      end else if (high_water < N_SLOTS) begin
        pick = high_water;
        gen_mem[pick] = gen_t'(1);
        high_water++;
      end
      if (pick >= 0) begin
        live[pick] = w.start_alive;
        r.slot_out = slot_t'(pick);
        r.generation_out = gen_mem[pick];
        r.ok = 1'b1;
      end else begin
        r.full_res = 1'b1;
      end
    end else if (w.operation <= OP_CHECK) begin
      seen = (int'(w.slot_in) < high_water);
      r.slot_out = w.slot_in;
      r.generation_out = seen ? gen_mem[w.slot_in] : '0;
      case (w.operation)
        OP_ACTIVATE: begin
          if (seen) live[w.slot_in] = 1'b1;
        end
        OP_KILL: begin
          if (seen && live[w.slot_in]) begin
            live[w.slot_in] = 1'b0;
            r.ok = 1'b1;
          end
        end
        OP_CHECK: begin
          r.ok = (w.generation_in != '0) && seen && live[w.slot_in] &&
                 (gen_mem[w.slot_in] == w.generation_in);
        end
        default: begin
        end
      endcase
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reply_q.delete();
      foreach (live[i]) live[i] = 1'b0;
      high_water = 0;
      fail_count_o = 0;
      waiting_o = 0;
      checked_o = 0;
      full_seen_o = 0;
      slots_in_use_o = 0;
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        checked_o++;
        if (reply_q.size() == 0) begin
          if (fail_count_o < 10) $display("reply %0d arrived with nothing pending", checked_o);
          fail_count_o++;
        end else begin
          want = reply_q.pop_front();
          if (rsp_word_i.slot_out !== want.slot_out ||
              rsp_word_i.generation_out !== want.generation_out ||
              rsp_word_i.ok !== want.ok || rsp_word_i.full_res !== want.full_res) begin
            if (fail_count_o < 10) begin
              $display("reply %0d: expected slot %0d gen %0d ok %b full %b",
                       checked_o, want.slot_out, want.generation_out, want.ok,
                       want.full_res);
              $display("reply %0d: got slot %0d gen %0d ok %b full %b",
                       checked_o, rsp_word_i.slot_out, rsp_word_i.generation_out,
                       rsp_word_i.ok, rsp_word_i.full_res);
            end
            fail_count_o++;
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        want = next_reply(req_word_i);
        if (want.full_res) full_seen_o++;
        reply_q.insert(reply_q.size(), want);
      end
      waiting_o = reply_q.size();
      slots_in_use_o = high_water;
    end
  end

endmodule

// ===== tb/tb_generational_slot_allocator_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the generational slot allocator: clock, reset, request
// stimulus and reply back-pressure; gsa_handle_checker does the checking.
// Depends on gsa_pkg, gsa_stream_if, generational_slot_allocator_top and gsa_handle_checker.
module tb_generational_slot_allocator_top;
  import gsa_pkg::*;

  localparam int N_SLOTS = SLOTS_DEF;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic no_idle;
  int   fail_count;
  int   waiting;
  int   checked;
  int   full_seen;
  int   in_use;
  int   words_sent;

  gsa_stream_if #(.T(req_t)) req_if ();
  gsa_stream_if #(.T(rsp_t)) rsp_if ();

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  generational_slot_allocator_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  gsa_handle_checker #(.N_SLOTS(N_SLOTS)) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (req_if.valid),
    .req_ready_i    (req_if.ready),
    .req_word_i     (req_if.payload),
    .rsp_valid_i    (rsp_if.valid),
    .rsp_ready_i    (rsp_if.ready),
    .rsp_word_i     (rsp_if.payload),
    .fail_count_o   (fail_count),
    .waiting_o      (waiting),
    .checked_o      (checked),
    .full_seen_o    (full_seen),
    .slots_in_use_o (in_use)
  );

  task automatic send_word(op_e op, slot_t s, gen_t g, logic a);
    req_t w;
    w.operation = op;
    w.slot_in = s;
    w.generation_in = g;
    w.start_alive = a;
    while (!no_idle && $urandom_range(0, 99) < 6) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid = 1'b1;
    req_if.payload = w;
    do @(posedge clk_i); while (!req_if.ready);
    words_sent++;
    @(negedge clk_i);
    req_if.valid = 1'b0;
  endtask

  task automatic random_word(int create_pct, int kill_pct, int alive_pct);
    int    r;
    int    top_slot;
    op_e   op;
    slot_t s;
    gen_t  g;
    r = $urandom_range(0, 99);
    if (r < create_pct) begin
      op = OP_CREATE;
    end else if (r < create_pct + kill_pct) begin
      op = OP_KILL;
    end else begin
      case ($urandom_range(0, 3))
        0: op = OP_ACTIVATE;
        1: op = OP_GET;
        default: op = OP_CHECK;
      endcase
    end
    top_slot = (in_use == 0) ? 0 : in_use - 1;
    if ($urandom_range(0, 99) < 85) s = slot_t'($urandom_range(0, top_slot));
    else s = slot_t'($urandom_range(0, N_SLOTS - 1));
    case ($urandom_range(0, 9))
      0: g = '0;
      1, 2: g = gen_t'($urandom);
      default: g = gen_t'($urandom_range(1, 4));
    endcase
    send_word(op, s, g, $urandom_range(0, 99) < alive_pct);
  endtask

  task automatic await_replies();
    while (waiting != 0) @(negedge clk_i);
  endtask

  initial begin : reply_side
    int   hold_left;
    logic held_once;
    rsp_if.ready = 1'b0;
    held_once = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (!held_once && checked >= 40) begin
        held_once = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        rsp_if.ready = 1'b0;
        hold_left--;
      end else begin
        rsp_if.ready = no_idle || ($urandom_range(0, 99) >= 6);
      end
    end
  end

  initial begin
    #400_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int n;
    int fails;
    req_if.valid = 1'b0;
    req_if.payload = '0;
    no_idle = 1'b0;
    words_sent = 0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_word(OP_GET, slot_t'(0), gen_t'(0), 1'b0);
    send_word(OP_CHECK, slot_t'(N_SLOTS - 1), '1, 1'b1);
    send_word(OP_ACTIVATE, slot_t'(5), gen_t'(1), 1'b0);
    send_word(OP_KILL, slot_t'(N_SLOTS - 1), '1, 1'b1);
    send_word(OP_CREATE, '1, '1, 1'b1);
    send_word(OP_CREATE, slot_t'(0), gen_t'(0), 1'b0);
    send_word(OP_CHECK, slot_t'(1), gen_t'(1), 1'b0);
    send_word(OP_ACTIVATE, slot_t'(1), gen_t'(0), 1'b0);
    send_word(OP_CHECK, slot_t'(1), gen_t'(1), 1'b0);
    send_word(OP_CHECK, slot_t'(1), gen_t'(0), 1'b0);
    send_word(OP_CHECK, slot_t'(1), gen_t'(2), 1'b0);
    send_word(OP_KILL, slot_t'(1), gen_t'(0), 1'b0);
    send_word(OP_KILL, slot_t'(1), gen_t'(0), 1'b0);
    send_word(OP_GET, slot_t'(1), gen_t'(0), 1'b0);
    send_word(OP_CREATE, slot_t'(0), gen_t'(0), 1'b1);
    send_word(OP_ACTIVATE, slot_t'(0), gen_t'(0), 1'b0);
    send_word(OP_CHECK, slot_t'(2), gen_t'(1), 1'b1);
    send_word(OP_GET, slot_t'(N_SLOTS - 1), gen_t'(0), 1'b0);
    await_replies();

    repeat (200) random_word(35, 20, 60);
    await_replies();

    n = 0;
    while (in_use < N_SLOTS && n < 2500) begin
      random_word(85, 4, 90);
      n++;
    end
    no_idle = 1'b1;
    repeat (120) random_word(80, 6, 90);
    no_idle = 1'b0;
    await_replies();

    repeat (100) random_word(30, 25, 50);

    req_if.valid = 1'b0;
    n = 0;
    while (waiting != 0 && n < 100000) begin
      @(negedge clk_i);
      n++;
    end
    repeat (20) @(negedge clk_i);

    fails = fail_count + waiting;
    $display("Sent %0d request words, checked %0d replies, %0d of them full.",
             words_sent, checked, full_seen);
    $display("Covered slot reuse, stale and invalid handles, a full table, a long reply stall.");
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
